// File: hw/rtl/rpu_pkg.sv
// Shared types and constants of the RMSProp parameter update block.
// Used by every module under hw/rtl except rpu_ram; depends on nothing else.
package rpu_pkg;

   localparam int NUM_ELEMENTS  = 65536;
   localparam int MS_ADDR_W     = $clog2(NUM_ELEMENTS);
   localparam int IDX_W         = 16;
   localparam int DATA_W        = 32;
   localparam int RATE_W        = 16;
   localparam int FRAC_W        = 24;
   localparam int ROOT_W        = 28;
   localparam int QUO_W         = 49;
   localparam int CSR_IDX_W     = 2;

   localparam int FRONTQ_DEPTH  = 4;
   localparam int FRONTQ_ADDR_W = $clog2(FRONTQ_DEPTH);
   localparam int RSPQ_DEPTH    = 128;
   localparam int RSPQ_ADDR_W   = $clog2(RSPQ_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON_TERM  = 2'd2;

   localparam logic [RATE_W-1:0] LEARNING_RATE_RESET = 16'd66;
   localparam logic [RATE_W-1:0] DECAY_RATE_RESET    = 16'd58982;
   localparam logic [DATA_W-1:0] EPSILON_TERM_RESET  = 32'd2;

   // One classified input transaction.
   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic                     in_range;
      logic [DATA_W-1:0]        mag;
      logic                     neg;
      logic                     zero;
      logic signed [DATA_W-1:0] param;
   } item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_param;
      logic signed [DATA_W-1:0] update_delta;
   } result_type;

   typedef struct packed {
      logic [RATE_W-1:0] learning_rate;
      logic [RATE_W-1:0] decay_rate;
      logic [DATA_W-1:0] epsilon_term;
   } csr_type;

endpackage

// File: hw/rtl/rpu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package needed.
module rpu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rpu_front.sv
// Front end: accepts request transactions, classifies the gradient and queues them.
// Depends on rpu_pkg.
module rpu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpu_pkg::IDX_W-1:0]           req_element_index,
   input  logic signed [rpu_pkg::DATA_W-1:0]   req_gradient_value,
   input  logic signed [rpu_pkg::DATA_W-1:0]   req_param_value,
   input  logic                                clearing,
   input  logic                                pop,
   output logic                                out_valid,
   output rpu_pkg::item_type                   out_item
);
   import rpu_pkg::*;

   item_type                 fq_ff [FRONTQ_DEPTH];
   logic [FRONTQ_ADDR_W-1:0] wptr_ff, wptr_in;
   logic [FRONTQ_ADDR_W-1:0] rptr_ff, rptr_in;
   logic [FRONTQ_ADDR_W:0]   cnt_ff, cnt_in;
   item_type                 class_item;
   logic                     push;

   always_comb begin
      class_item.idx      = req_element_index;
      class_item.in_range = 32'(req_element_index) < 32'(NUM_ELEMENTS);
      class_item.neg      = req_gradient_value[DATA_W-1];
      class_item.mag      = req_gradient_value[DATA_W-1] ? DATA_W'(-req_gradient_value)
                                                         : DATA_W'(req_gradient_value);
      class_item.zero     = (req_gradient_value == '0);
      class_item.param    = req_param_value;
   end

   assign req_stall = (cnt_ff == (FRONTQ_ADDR_W+1)'(FRONTQ_DEPTH)) || clearing;
   assign push      = req_valid && !req_stall;
   assign out_valid = (cnt_ff != '0);
   assign out_item  = fq_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (FRONTQ_ADDR_W+1)'(push) - (FRONTQ_ADDR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         fq_ff[wptr_ff] <= class_item;
      end
   end

endmodule

// File: hw/rtl/rpu_mstore.sv
// Mean square store: read-modify-write of the per-element running mean square,
// with forwarding between back-to-back hits and a clearing sweep after reset.
// Depends on rpu_pkg and rpu_ram.
module rpu_mstore (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      issue,
   input  rpu_pkg::item_type         issue_item,
   input  rpu_pkg::csr_type          csr,
   output logic                      clearing,
   output logic                      out_valid,
   output rpu_pkg::item_type         out_item,
   output logic [rpu_pkg::DATA_W-1:0] out_ms
);
   import rpu_pkg::*;

   logic                   clearing_ff, clearing_in;
   logic [MS_ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   logic                   s0_valid_ff;
   item_type               s0_item_ff;
   logic [2*DATA_W-1:0]    s0_prod_ff;
   logic                   s1_valid_ff;
   item_type               s1_item_ff;
   logic [DATA_W-1:0]      s1_gsq_ff, s1_gsq_in;
   logic                   s2_valid_ff;
   item_type               s2_item_ff;
   logic [DATA_W-1:0]      s2_ms_ff, s2_ms_in;
   logic                   s3_valid_ff;
   logic [IDX_W-1:0]       s3_idx_ff;
   logic [DATA_W-1:0]      s3_ms_ff;

   logic [DATA_W-1:0]      rd_data;
   logic [DATA_W-1:0]      v_old;
   logic [RATE_W:0]        one_minus_rho;
   logic [49:0]            v_sum;
   logic                   wr_en;
   logic [MS_ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]      wr_data;

   rpu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_ELEMENTS)
   ) u_ms_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (MS_ADDR_W'(s0_item_ff.idx)),
      .rd_data (rd_data)
   );

   // Squared gradient in Q8.24, saturated.
   assign s1_gsq_in = (s0_prod_ff[2*DATA_W-1:DATA_W+FRAC_W] != '0) ? '1
                      : s0_prod_ff[DATA_W+FRAC_W-1:FRAC_W];

   // The entry may still be in flight in the two stages that write it.
   always_comb begin
      if (!s1_item_ff.in_range) begin
         v_old = '0;
      end else if (s2_valid_ff && s2_item_ff.in_range && (s2_item_ff.idx == s1_item_ff.idx)) begin
         v_old = s2_ms_ff;
      end else if (s3_valid_ff && (s3_idx_ff == s1_item_ff.idx)) begin
         v_old = s3_ms_ff;
      end else begin
         v_old = rd_data;
      end
   end

   assign one_minus_rho = (RATE_W+1)'(1 << RATE_W) - {1'b0, csr.decay_rate};
   assign v_sum    = 50'(csr.decay_rate * v_old) + 50'(one_minus_rho * s1_gsq_ff)
                     + 50'(1 << (RATE_W-1));
   assign s2_ms_in = v_sum[RATE_W+DATA_W-1:RATE_W];

   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s2_valid_ff && s2_item_ff.in_range;
         wr_addr = MS_ADDR_W'(s2_item_ff.idx);
         wr_data = s2_ms_ff;
      end
   end

   always_comb begin
      clr_addr_in = clearing_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
      clearing_in = clearing_ff && (clr_addr_ff != MS_ADDR_W'(NUM_ELEMENTS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         s0_valid_ff <= issue;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_item_ff.in_range;
      end
      s0_item_ff <= issue_item;
      s0_prod_ff <= issue_item.mag * issue_item.mag;
      s1_item_ff <= s0_item_ff;
      s1_gsq_ff  <= s1_gsq_in;
      s2_item_ff <= s1_item_ff;
      s2_ms_ff   <= s2_ms_in;
      s3_idx_ff  <= s2_item_ff.idx;
      s3_ms_ff   <= s2_ms_ff;
   end

   assign clearing  = clearing_ff;
   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;
   assign out_ms    = s2_ms_ff;

endmodule

// File: hw/rtl/rpu_core.sv
// Arithmetic back end: pipelined square root, pipelined division, scaling by the
// learning rate and the parameter update, one transaction per cycle.
// Depends on rpu_pkg.
module rpu_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rpu_pkg::item_type          in_item,
   input  logic [rpu_pkg::DATA_W-1:0] in_ms,
   input  rpu_pkg::csr_type           csr,
   output logic                       out_valid,
   output rpu_pkg::result_type        out_result
);
   import rpu_pkg::*;

   localparam int RAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 3;
   localparam int DREM_W  = ROOT_W + 1;
   localparam int HI_W    = QUO_W - DATA_W;
   localparam int SHIFT_W = QUO_W - FRAC_W;

   localparam logic [QUO_W-1:0]  Q_CAP = QUO_W'(1) << (QUO_W - 1);
   localparam logic [QUO_W-1:0]  M_CAP = QUO_W'(1) << (DATA_W - 1);
   localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic [DATA_W-1:0]        mag;
      logic                     neg;
      logic                     zero;
      logic signed [DATA_W-1:0] param;
   } carry_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      carry_type         cy;
   } sq_type;

   typedef struct packed {
      logic [ROOT_W-1:0] r;
      logic [DREM_W-1:0] rem;
      logic [QUO_W-1:0]  dd;
      logic [QUO_W-1:0]  q;
      logic              ovf;
      logic              rzero;
      carry_type         cy;
   } dv_type;

   sq_type  sq_ff [ROOT_W+1];
   sq_type  sq_in [ROOT_W+1];
   logic [ROOT_W:0] sq_v_ff;
   dv_type  dv_ff [QUO_W+1];
   dv_type  dv_in [QUO_W+1];
   logic [QUO_W:0]  dv_v_ff;

   logic [DATA_W:0] s_sum;

   // Seed of the square root: s = v + eps, saturated, as a Q8.48 radicand.
   always_comb begin
      s_sum           = {1'b0, in_ms} + {1'b0, csr.epsilon_term};
      sq_in[0].rad    = {(s_sum[DATA_W] ? {DATA_W{1'b1}} : s_sum[DATA_W-1:0]), FRAC_W'(0)};
      sq_in[0].rem    = '0;
      sq_in[0].root   = '0;
      sq_in[0].cy.mag   = in_item.mag;
      sq_in[0].cy.neg   = in_item.neg;
      sq_in[0].cy.zero  = in_item.zero;
      sq_in[0].cy.param = in_item.param;
   end

   // One root bit per stage.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] trial;
      always_comb begin
         sh    = {sq_ff[k].rem[REM_W-3:0], sq_ff[k].rad[RAD_W-1 -: 2]};
         trial = {1'b0, sq_ff[k].root, 2'b01};
         sq_in[k+1]     = sq_ff[k];
         sq_in[k+1].rad = sq_ff[k].rad << 2;
         if (sh >= trial) begin
            sq_in[k+1].rem  = sh - trial;
            sq_in[k+1].root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem  = sh;
            sq_in[k+1].root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Division setup. A quotient of 2^QUO_W or more is flagged up front so that only
   // the low QUO_W quotient bits need to be developed.
   always_comb begin
      dv_in[0].r     = sq_ff[ROOT_W].root;
      dv_in[0].rzero = (sq_ff[ROOT_W].root == '0);
      dv_in[0].ovf   = (53'(sq_ff[ROOT_W].cy.mag) >= {sq_ff[ROOT_W].root, SHIFT_W'(0)});
      dv_in[0].rem   = DREM_W'(sq_ff[ROOT_W].cy.mag[DATA_W-1:SHIFT_W]);
      dv_in[0].dd    = {sq_ff[ROOT_W].cy.mag[SHIFT_W-1:0], FRAC_W'(0)};
      dv_in[0].q     = '0;
      dv_in[0].cy    = sq_ff[ROOT_W].cy;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      logic [DREM_W-1:0] sh;
      always_comb begin
         sh            = {dv_ff[k].rem[DREM_W-2:0], dv_ff[k].dd[QUO_W-1]};
         dv_in[k+1]    = dv_ff[k];
         dv_in[k+1].dd = dv_ff[k].dd << 1;
         if (sh >= {1'b0, dv_ff[k].r}) begin
            dv_in[k+1].rem = sh - {1'b0, dv_ff[k].r};
            dv_in[k+1].q   = {dv_ff[k].q[QUO_W-2:0], 1'b1};
         end else begin
            dv_in[k+1].rem = sh;
            dv_in[k+1].q   = {dv_ff[k].q[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
         dv_v_ff <= '0;
      end else begin
         sq_v_ff <= {sq_v_ff[ROOT_W-1:0], in_valid};
         dv_v_ff <= {dv_v_ff[QUO_W-1:0], sq_v_ff[ROOT_W]};
      end
      sq_ff <= sq_in;
      dv_ff <= dv_in;
   end

   // Scale by the learning rate, split into two partial products.
   logic [QUO_W-1:0]            qc;
   logic                        mul_v_ff;
   logic [RATE_W+DATA_W-1:0]    plo_ff, plo_in;
   logic [RATE_W+HI_W-1:0]      phi_ff, phi_in;
   logic                        mul_rzero_ff;
   carry_type                   mul_cy_ff;

   always_comb begin
      qc = (dv_ff[QUO_W].ovf || (dv_ff[QUO_W].q > Q_CAP)) ? Q_CAP : dv_ff[QUO_W].q;
      plo_in = (RATE_W+DATA_W)'(csr.learning_rate) * (RATE_W+DATA_W)'(qc[DATA_W-1:0]);
      phi_in = (RATE_W+HI_W)'(csr.learning_rate) * (RATE_W+HI_W)'(qc[QUO_W-1:DATA_W]);
   end

   logic [RATE_W+QUO_W-1:0]     m_sum;
   logic [DATA_W-1:0]           m_cap;
   logic                        pos;
   logic signed [DATA_W-1:0]    delta_in;
   logic                        dl_v_ff;
   logic signed [DATA_W-1:0]    delta_ff;
   logic signed [DATA_W-1:0]    dl_param_ff;

   always_comb begin
      m_sum = {phi_ff, DATA_W'(0)} + (RATE_W+QUO_W)'(plo_ff);
      m_cap = (m_sum[RATE_W+QUO_W-1:RATE_W] > M_CAP) ? DATA_W'(M_CAP)
              : m_sum[RATE_W+DATA_W-1:RATE_W];
      pos   = !mul_cy_ff.neg && !mul_cy_ff.zero;
      if (mul_cy_ff.zero) begin
         delta_in = '0;
      end else if (mul_rzero_ff) begin
         delta_in = pos ? S_MIN : S_MAX;
      end else if (pos) begin
         delta_in = -$signed(m_cap);
      end else if (m_cap[DATA_W-1]) begin
         delta_in = S_MAX;
      end else begin
         delta_in = $signed(m_cap);
      end
   end

   logic signed [DATA_W:0]      np_sum;
   logic                        np_v_ff;
   result_type                  np_ff, np_in;

   // Both bounds are compared as signed 33-bit values.
   always_comb begin
      np_sum = {dl_param_ff[DATA_W-1], dl_param_ff} + {delta_ff[DATA_W-1], delta_ff};
      if (np_sum > $signed({1'b0, S_MAX})) begin
         np_in.new_param = S_MAX;
      end else if (np_sum < $signed({1'b1, S_MIN})) begin
         np_in.new_param = S_MIN;
      end else begin
         np_in.new_param = np_sum[DATA_W-1:0];
      end
      np_in.update_delta = delta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
         dl_v_ff  <= 1'b0;
         np_v_ff  <= 1'b0;
      end else begin
         mul_v_ff <= dv_v_ff[QUO_W];
         dl_v_ff  <= mul_v_ff;
         np_v_ff  <= dl_v_ff;
      end
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      mul_rzero_ff <= dv_ff[QUO_W].rzero;
      mul_cy_ff    <= dv_ff[QUO_W].cy;
      delta_ff     <= delta_in;
      dl_param_ff  <= mul_cy_ff.param;
      np_ff        <= np_in;
   end

   assign out_valid  = np_v_ff;
   assign out_result = np_ff;

endmodule

// File: hw/rtl/rpu_rspq.sv
// Result queue: RAM-backed FIFO with a two-entry output buffer, plus the credit
// count that keeps the arithmetic pipeline from ever overrunning it.
// Depends on rpu_pkg and rpu_ram.
module rpu_rspq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              issue,
   input  logic                              wr_valid,
   input  rpu_pkg::result_type               wr_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic signed [rpu_pkg::DATA_W-1:0] rsp_new_param,
   output logic signed [rpu_pkg::DATA_W-1:0] rsp_update_delta,
   output logic                              room
);
   import rpu_pkg::*;

   localparam int RES_W = $bits(result_type);

   logic [RSPQ_ADDR_W:0]   reserved_ff, reserved_in;
   logic [RSPQ_ADDR_W:0]   cnt_ff, cnt_in;
   logic [RSPQ_ADDR_W-1:0] wptr_ff, rptr_ff;
   logic                   pend_ff;
   result_type             ob0_ff, ob0_in;
   result_type             ob1_ff, ob1_in;
   logic [1:0]             ob_cnt_ff, ob_cnt_in;
   logic [RES_W-1:0]       rd_data;
   logic                   take;
   logic                   rd_issue;
   logic [2:0]             used;

   rpu_ram #(
      .WIDTH (RES_W),
      .DEPTH (RSPQ_DEPTH)
   ) u_rsp_ram (
      .clock   (clock),
      .wr_en   (wr_valid),
      .wr_addr (wptr_ff),
      .wr_data (wr_data),
      .rd_addr (rptr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid        = (ob_cnt_ff != 2'd0);
   assign rsp_new_param    = ob0_ff.new_param;
   assign rsp_update_delta = ob0_ff.update_delta;
   assign take             = rsp_valid && !rsp_stall;
   assign room             = reserved_ff < (RSPQ_ADDR_W+1)'(RSPQ_DEPTH);

   // A read is started only if its data is sure to find a free buffer slot.
   assign used     = 3'(ob_cnt_ff) + 3'(pend_ff);
   assign rd_issue = (cnt_ff != '0) && (take ? (used <= 3'd2) : (used <= 3'd1));

   always_comb begin
      reserved_in = reserved_ff + (RSPQ_ADDR_W+1)'(issue) - (RSPQ_ADDR_W+1)'(take);
      cnt_in      = cnt_ff + (RSPQ_ADDR_W+1)'(wr_valid) - (RSPQ_ADDR_W+1)'(rd_issue);
      ob0_in      = ob0_ff;
      ob1_in      = ob1_ff;
      ob_cnt_in   = ob_cnt_ff;
      if (take) begin
         ob0_in    = ob1_ff;
         ob_cnt_in = ob_cnt_ff - 2'd1;
      end
      if (pend_ff) begin
         if (ob_cnt_in == 2'd0) begin
            ob0_in = result_type'(rd_data);
         end else begin
            ob1_in = result_type'(rd_data);
         end
         ob_cnt_in = ob_cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         cnt_ff      <= '0;
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         pend_ff     <= 1'b0;
         ob_cnt_ff   <= 2'd0;
      end else begin
         reserved_ff <= reserved_in;
         cnt_ff      <= cnt_in;
         wptr_ff     <= wr_valid ? wptr_ff + 1'b1 : wptr_ff;
         rptr_ff     <= rd_issue ? rptr_ff + 1'b1 : rptr_ff;
         pend_ff     <= rd_issue;
         ob_cnt_ff   <= ob_cnt_in;
      end
      ob0_ff <= ob0_in;
      ob1_ff <= ob1_in;
   end

endmodule

// File: hw/rtl/rmsprop_parameter_update.sv
// RMSProp parameter update, one element per transaction, Q8.24 fixed point.
// Request channel (req_valid / req_stall): element index, gradient and current
// parameter. Result channel (rsp_valid / rsp_stall): new parameter and the applied
// update delta, one result transaction per request, in request order.
// A transaction is taken at a clock edge where valid is high and stall is low.
// Throughput is one transaction per cycle unless a stall or the clearing sweep holds
// the flow. With empty queues and no stall, a request passes the mean square
// read-modify-write, the square root (a seed stage, then one root bit per stage),
// the one-bit-per-stage divider, scaling and the update, and the result queue.
// Reset restores the register defaults and then sweeps the mean square RAM to zero,
// one entry per cycle, all 65536 of them; req_stall stays high during the sweep while
// configuration writes are still taken. A stalled receiver fills the 128-entry result
// queue; the front end keeps taking requests until its own 4-entry queue fills.
// Configuration registers: index 0 learning rate, 1 decay rate, 2 epsilon.
module rmsprop_parameter_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpu_pkg::IDX_W-1:0]           req_element_index,
   input  logic signed [rpu_pkg::DATA_W-1:0]   req_gradient_value,
   input  logic signed [rpu_pkg::DATA_W-1:0]   req_param_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rpu_pkg::DATA_W-1:0]   rsp_new_param,
   output logic signed [rpu_pkg::DATA_W-1:0]   rsp_update_delta,
   input  logic                                csr_wr_en,
   input  logic [rpu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rpu_pkg::DATA_W-1:0]          csr_wr_data
);
   import rpu_pkg::*;

   csr_type             csr_ff;
   logic                clearing;
   logic                front_valid;
   item_type            front_item;
   logic                room;
   logic                issue;
   logic                store_valid;
   item_type            store_item;
   logic [DATA_W-1:0]   store_ms;
   logic                core_valid;
   result_type          core_result;

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.learning_rate <= LEARNING_RATE_RESET;
         csr_ff.decay_rate    <= DECAY_RATE_RESET;
         csr_ff.epsilon_term  <= EPSILON_TERM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LEARNING_RATE: begin
               csr_ff.learning_rate <= csr_wr_data[RATE_W-1:0];
            end
            CSR_DECAY_RATE: begin
               csr_ff.decay_rate <= csr_wr_data[RATE_W-1:0];
            end
            CSR_EPSILON_TERM: begin
               csr_ff.epsilon_term <= csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // The back end never stalls: a transaction leaves the front queue only when the
   // result queue has a slot reserved for it.
   assign issue = front_valid && room;

   rpu_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_element_index  (req_element_index),
      .req_gradient_value (req_gradient_value),
      .req_param_value    (req_param_value),
      .clearing           (clearing),
      .pop                (issue),
      .out_valid          (front_valid),
      .out_item           (front_item)
   );

   rpu_mstore u_mstore (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_item (front_item),
      .csr        (csr_ff),
      .clearing   (clearing),
      .out_valid  (store_valid),
      .out_item   (store_item),
      .out_ms     (store_ms)
   );

   rpu_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (store_valid),
      .in_item    (store_item),
      .in_ms      (store_ms),
      .csr        (csr_ff),
      .out_valid  (core_valid),
      .out_result (core_result)
   );

   rpu_rspq u_rspq (
      .clock            (clock),
      .reset            (reset),
      .issue            (issue),
      .wr_valid         (core_valid),
      .wr_data          (core_result),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_new_param    (rsp_new_param),
      .rsp_update_delta (rsp_update_delta),
      .room             (room)
   );

`ifndef ASSERT_OFF
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("request taken during the mean square clearing sweep");

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid)
      else $error("result offered during the mean square clearing sweep");

   a_clear_no_work: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!issue && !store_valid && !core_valid))
      else $error("transaction in the back end during the clearing sweep");
`endif

endmodule
